// File: rtl/btoi_pkg.sv
// Shared types and constants for the base string to integer converter.
package btoi_pkg;

  // Number of digit character slots held by the configuration registers
  localparam int unsigned DIGIT_SLOTS = 32;
  localparam int unsigned DIGIT_W     = 5;

  // Character codes
  localparam logic [7:0] CHAR_TAB      = 8'd9;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_PLUS     = 8'd43;
  localparam logic [7:0] CHAR_MINUS    = 8'd45;
  localparam logic [7:0] CHAR_PRINT_LO = 8'd33;
  localparam logic [7:0] CHAR_PRINT_HI = 8'd126;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_RADIX_LENGTH = 3'd0,
    CFG_DIGIT_A      = 3'd1,
    CFG_DIGIT_B      = 3'd2,
    CFG_DIGIT_C      = 3'd3,
    CFG_DIGIT_D      = 3'd4
  } cfg_index_t;

  // Parse phase of the current string
  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } parse_phase_t;

  // Digit set check and byte match results
  typedef struct packed {
    logic               set_valid;
    logic               hit;
    logic [DIGIT_W-1:0] digit;
  } btoi_match_t;

endpackage

// File: rtl/base_string_to_integer.sv
// Top level of the streaming base string to integer converter.
//
// Takes one text byte per cycle on the input channel and returns one signed
// 32-bit result for each string, on its last byte. A byte is held in an input
// register and folded into the parse state from that register; the result of
// the last byte is loaded into the output register, and a new byte can be
// accepted every cycle. The rate is set by the accumulator update
// acc * radix + digit, one 32 by 6 bit multiply-add per byte, fed by a
// parallel compare against all digit characters. The input stalls only while
// a result waits in the output register and the next last byte is pending.
// Digit characters and radix come from the configuration port; the user must
// write them only while no string is in progress (the block does not check).
module base_string_to_integer
  import btoi_pkg::*;
#(
  parameter int unsigned MAX_RADIX = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] parsed_value,
  output logic               digits_valid
);

  // Configuration registers
  logic [5:0]             radix_length;
  logic [3:0][63:0]       digit_regs;
  logic [DIGIT_SLOTS-1:0][7:0] digit_chars;

  // Input stage
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;
  logic       advance;

  // Parse state
  parse_phase_t phase, phase_next;
  logic         negative, negative_next;
  logic [31:0]  accumulator, accumulator_next;

  logic [31:0]  result_next;
  logic [37:0]  product;
  logic         consumed;
  btoi_match_t  match;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length <= '0;
      digit_regs   <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_RADIX_LENGTH: radix_length  <= cfg_data[5:0];
        CFG_DIGIT_A:      digit_regs[0] <= cfg_data;
        CFG_DIGIT_B:      digit_regs[1] <= cfg_data;
        CFG_DIGIT_C:      digit_regs[2] <= cfg_data;
        CFG_DIGIT_D:      digit_regs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign digit_chars = digit_regs;

  btoi_digit_set #(
    .MAX_RADIX(MAX_RADIX)
  ) u_digit_set (
    .radix_length(radix_length),
    .digit_chars (digit_chars),
    .text_byte   (s_byte),
    .match       (match)
  );

  // Advance the held byte unless its result would overwrite a waiting one
  assign advance  = s_valid && (!s_last || !out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_byte <= text_byte;
      s_last <= last_byte;
    end
  end

  assign product = accumulator * {26'd0, radix_length};

  // Walk the byte through the whitespace, sign and digit phases
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    consumed         = 1'b0;
    if (phase_next == PH_SPACE) begin
      if (((s_byte >= CHAR_TAB) && (s_byte <= CHAR_CR)) || (s_byte == CHAR_SPACE)) begin
        consumed = 1'b1;
      end else begin
        phase_next = PH_SIGN;
      end
    end
    if (!consumed && (phase_next == PH_SIGN)) begin
      if ((s_byte == CHAR_PLUS) || (s_byte == CHAR_MINUS)) begin
        if (s_byte == CHAR_MINUS) begin
          negative_next = !negative;
        end
        consumed = 1'b1;
      end else begin
        phase_next = PH_DIGITS;
      end
    end
    if (!consumed && (phase_next == PH_DIGITS)) begin
      if (match.set_valid && match.hit) begin
        accumulator_next = product[31:0] + {27'd0, match.digit};
      end else begin
        phase_next = PH_DONE;
      end
    end
    result_next = '0;
    if (match.set_valid) begin
      result_next = negative_next ? (32'd0 - accumulator_next) : accumulator_next;
    end
  end

  // Update parse state; restart on the last byte of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (advance) begin
      if (s_last) begin
        phase       <= PH_SPACE;
        negative    <= 1'b0;
        accumulator <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_last) begin
      parsed_value <= signed'(result_next);
      digits_valid <= match.set_valid;
    end
  end

  // Assertions
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (phase == PH_SPACE) && !negative && (accumulator == 32'd0))
    else $error("parse state not cleared by reset");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && s_last) |=> (phase == PH_SPACE) && !negative && (accumulator == 32'd0))
    else $error("parse state not cleared after last byte");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && s_last) |=> out_valid)
    else $error("result not presented after last byte");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    (advance && s_last && !match.set_valid) |=> (parsed_value == 32'sd0) && !digits_valid)
    else $error("invalid digit set gave a nonzero value");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s_valid |-> in_ready)
    else $error("input stalled with empty stage");

endmodule

// File: rtl/btoi_digit_set.sv
// Digit set validity check and parallel digit match for one text byte.
module btoi_digit_set
  import btoi_pkg::*;
#(
  parameter int unsigned MAX_RADIX = 32
) (
  input  logic [5:0]                   radix_length,
  input  logic [DIGIT_SLOTS-1:0][7:0]  digit_chars,
  input  logic [7:0]                   text_byte,
  output btoi_match_t                  match
);

  logic [MAX_RADIX-1:0] in_use;
  logic [MAX_RADIX-1:0] bad_char;
  logic [MAX_RADIX-1:0] dup_char;
  logic [MAX_RADIX-1:0] hit;
  logic                 len_ok;
  logic [DIGIT_W-1:0]   digit;

  // Flag slots in use, bad characters and repeats
  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++) begin
      in_use[i]   = 6'(i) < radix_length;
      bad_char[i] = in_use[i] &&
                    ((digit_chars[i] < CHAR_PRINT_LO) || (digit_chars[i] > CHAR_PRINT_HI) ||
                     (digit_chars[i] == CHAR_PLUS) || (digit_chars[i] == CHAR_MINUS));
      dup_char[i] = 1'b0;
      for (int j = i + 1; j < MAX_RADIX; j++) begin
        if ((6'(j) < radix_length) && (digit_chars[i] == digit_chars[j])) begin
          dup_char[i] = 1'b1;
        end
      end
      hit[i] = in_use[i] && (digit_chars[i] == text_byte);
    end
  end

  // Encode the matching slot; a valid set has at most one hit
  always_comb begin
    digit = '0;
    for (int k = 0; k < MAX_RADIX; k++) begin
      if (hit[k]) begin
        digit = digit | DIGIT_W'(k);
      end
    end
  end

  assign len_ok = (radix_length >= 6'd2) && (radix_length <= 6'(MAX_RADIX));

  assign match.set_valid = len_ok && !(|bad_char) && !(|dup_char);
  assign match.hit       = |hit;
  assign match.digit     = digit;

endmodule
